@@ src/contiguous_fit_allocator_assert.svh @@
// Assertion macros for the contiguous fit allocator checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contiguous_fit_allocator: port assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contiguous_fit_allocator: port assertion failed");

`endif

@@ src/cfa_pkg.sv @@
// Shared types and constants for the contiguous fit allocator.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int CELLS_DEFAULT = 128;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        RS_OK      = 2'd0,
        RS_NO_FIT  = 2'd1,
        RS_NO_SUCH = 2'd2
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] request_size;
        logic [6:0] release_ordinal;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] start_index;
        logic [7:0] run_size;
        logic [7:0] occupied_cells;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DECIDE,
        S_NB_RD,
        S_NB_EV,
        S_SETUP,
        S_FILL_A,
        S_FILL_B,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic latch;
        logic rd_scan;
        logic eval;
        logic rd_nb;
        logic eval_nb;
        logic setup_a;
        logic setup_b;
        logic fill_wr;
        logic respond;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic zero_req;
        logic is_rel;
        logic scan_stop;
        logic found;
        logic has_nb;
        logic has_rem;
        logic fill_last;
    } dp_stat_t;

endpackage

@@ src/cfa_ctrl.sv @@
// Controller state machine of the contiguous fit allocator.
// Depends on cfa_pkg; drives the datapath through command and status structs.
`timescale 1ns / 1ps

module cfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cfa_pkg::dp_stat_t stat,
    output cfa_pkg::ctl_cmd_t cmd,
    output logic              busy
);

    cfa_pkg::state_t state_reg;
    cfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            cfa_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = cfa_pkg::S_IDLE;
                end
            end
            cfa_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = cfa_pkg::S_SCAN_RD;
                end
            end
            cfa_pkg::S_SCAN_RD:
            begin
                if (stat.zero_req)
                begin
                    state_next = cfa_pkg::S_RESP;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = cfa_pkg::S_SCAN_EV;
                end
            end
            cfa_pkg::S_SCAN_EV:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.scan_stop ? cfa_pkg::S_DECIDE : cfa_pkg::S_SCAN_RD;
            end
            cfa_pkg::S_DECIDE:
            begin
                if (!stat.found)
                begin
                    state_next = cfa_pkg::S_RESP;
                end
                else if (stat.is_rel && stat.has_nb)
                begin
                    state_next = cfa_pkg::S_NB_RD;
                end
                else
                begin
                    state_next = cfa_pkg::S_SETUP;
                end
            end
            cfa_pkg::S_NB_RD:
            begin
                cmd.rd_nb  = 1'b1;
                state_next = cfa_pkg::S_NB_EV;
            end
            cfa_pkg::S_NB_EV:
            begin
                cmd.eval_nb = 1'b1;
                state_next  = cfa_pkg::S_SETUP;
            end
            cfa_pkg::S_SETUP:
            begin
                cmd.setup_a = 1'b1;
                state_next  = cfa_pkg::S_FILL_A;
            end
            cfa_pkg::S_FILL_A:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    if (!stat.is_rel && stat.has_rem)
                    begin
                        cmd.setup_b = 1'b1;
                        state_next  = cfa_pkg::S_FILL_B;
                    end
                    else
                    begin
                        state_next = cfa_pkg::S_RESP;
                    end
                end
            end
            cfa_pkg::S_FILL_B:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = cfa_pkg::S_RESP;
                end
            end
            cfa_pkg::S_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = cfa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cfa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/cfa_datapath.sv @@
// Datapath of the contiguous fit allocator: cell memory, run walker, fill unit.
// Depends on cfa_pkg; steered by cfa_ctrl through command and status structs.
`timescale 1ns / 1ps

module cfa_datapath #(
    parameter int CELLS = cfa_pkg::CELLS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  cfa_pkg::req_t     request,
    input  cfa_pkg::ctl_cmd_t cmd,
    output cfa_pkg::dp_stat_t stat,
    output logic              done,
    output cfa_pkg::rsp_t     result
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LW = $clog2(CELLS + 1);
    localparam int VW = LW + 1;
    localparam int CW = (LW > 8) ? LW : 8;
    localparam int KW = ((AW + 1) > 7) ? (AW + 1) : 7;
    localparam logic [LW:0] CELLS_L = (LW + 1)'(CELLS);

    logic signed [VW-1:0] mem [CELLS];
    logic signed [VW-1:0] rdata_reg;

    logic [1:0]    mode_reg;
    cfa_pkg::op_t  op_reg;
    logic [7:0]    size_reg;
    logic [6:0]    ord_reg;
    logic [AW:0]   pos_reg,        pos_next;
    logic          found_reg,      found_next;
    logic [AW-1:0] at_reg,         at_next;
    logic [LW-1:0] best_reg,       best_next;
    logic [AW:0]   count_reg,      count_next;
    logic          prev_neg_reg,   prev_neg_next;
    logic [AW-1:0] prev_start_reg, prev_start_next;
    logic [LW-1:0] prev_len_reg,   prev_len_next;
    logic [AW-1:0] b_reg,          b_next;
    logic [LW-1:0] bsize_reg,      bsize_next;
    logic [AW-1:0] fill_ptr_reg,   fill_ptr_next;
    logic [LW-1:0] fill_cnt_reg,   fill_cnt_next;
    logic signed [VW-1:0] fill_val_reg, fill_val_next;
    logic [LW-1:0] occ_reg,        occ_next;
    logic          done_reg;
    cfa_pkg::rsp_t result_reg,     result_next;

    logic [AW:0]          nb_pos;
    logic [AW:0]          base;
    logic signed [VW-1:0] mag;
    logic [LW-1:0]        magl;
    logic [LW:0]          rem;
    logic [LW-1:0]        len;
    logic                 is_neg;
    logic                 is_pos;
    logic                 fits;
    logic                 hit;
    logic                 stop;
    logic                 at_end;
    logic [LW-1:0]        s_l;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic signed [VW-1:0] wr_data;

    assign nb_pos  = (AW + 1)'(b_reg) + (AW + 1)'(bsize_reg);
    assign base    = cmd.eval_nb ? nb_pos : pos_reg;
    assign is_neg  = rdata_reg[VW-1];
    assign is_pos  = !is_neg && (rdata_reg != '0);
    assign mag     = is_neg ? -rdata_reg : rdata_reg;
    assign magl    = LW'(mag);
    assign rem     = CELLS_L - (LW + 1)'(base);
    assign len     = (magl == '0) ? LW'(1) :
                     (((LW + 1)'(magl) > rem) ? LW'(rem) : magl);
    assign at_end  = ((LW + 1)'(pos_reg) + (LW + 1)'(len)) >= CELLS_L;
    assign fits    = is_neg && (CW'(len) >= CW'(size_reg));
    assign s_l     = LW'(size_reg);
    assign rd_addr = cmd.rd_nb ? nb_pos[AW-1:0] : pos_reg[AW-1:0];
    assign rd_en   = cmd.rd_scan || cmd.rd_nb;
    assign wr_en   = cmd.clr_wr || cmd.fill_wr;
    assign wr_data = cmd.clr_wr ? -(VW'(CELLS)) : fill_val_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_ptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Run walk: hole choice for allocation, block count for release.
    always_comb
    begin
        pos_next        = pos_reg;
        found_next      = found_reg;
        at_next         = at_reg;
        best_next       = best_reg;
        count_next      = count_reg;
        prev_neg_next   = prev_neg_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        b_next          = b_reg;
        bsize_next      = bsize_reg;
        hit             = 1'b0;
        stop            = at_end;
        if (cmd.latch)
        begin
            pos_next      = '0;
            found_next    = 1'b0;
            count_next    = '0;
            prev_neg_next = 1'b0;
        end
        else if (cmd.eval)
        begin
            pos_next = pos_reg + (AW + 1)'(len);
            if (op_reg == cfa_pkg::OP_ALLOC)
            begin
                if (mode_reg == cfa_pkg::FIT_BEST)
                begin
                    hit = fits && (!found_reg || (len < best_reg));
                    if (fits && (CW'(len) == CW'(size_reg)))
                    begin
                        stop = 1'b1;
                    end
                end
                else if (mode_reg == cfa_pkg::FIT_WORST)
                begin
                    hit = fits && (!found_reg || (len > best_reg));
                end
                else
                begin
                    hit = fits;
                    if (fits)
                    begin
                        stop = 1'b1;
                    end
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    at_next    = pos_reg[AW-1:0];
                    best_next  = len;
                end
            end
            else
            begin
                if (is_pos && (KW'(count_reg) == KW'(ord_reg)))
                begin
                    found_next = 1'b1;
                    b_next     = pos_reg[AW-1:0];
                    bsize_next = len;
                    at_next    = prev_neg_reg ? prev_start_reg : pos_reg[AW-1:0];
                    best_next  = prev_neg_reg ? (len + prev_len_reg) : len;
                    stop       = 1'b1;
                end
                else if (is_pos)
                begin
                    count_next = count_reg + 1'b1;
                end
                prev_neg_next   = is_neg;
                prev_start_next = pos_reg[AW-1:0];
                prev_len_next   = len;
            end
        end
        else if (cmd.eval_nb)
        begin
            if (is_neg)
            begin
                best_next = best_reg + len;
            end
        end
    end

    // Fill unit and result composition.
    always_comb
    begin
        fill_ptr_next = fill_ptr_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_val_next = fill_val_reg;
        occ_next      = occ_reg;
        result_next   = result_reg;
        if (cmd.clr_wr || cmd.fill_wr)
        begin
            fill_ptr_next = fill_ptr_reg + 1'b1;
            fill_cnt_next = fill_cnt_reg - 1'b1;
        end
        else if (cmd.setup_a)
        begin
            fill_ptr_next = at_reg;
            if (op_reg == cfa_pkg::OP_RELEASE)
            begin
                fill_cnt_next = best_reg;
                fill_val_next = -(VW'(best_reg));
            end
            else
            begin
                fill_cnt_next = s_l;
                fill_val_next = VW'(s_l);
            end
        end
        if (cmd.setup_b)
        begin
            fill_ptr_next = at_reg + AW'(s_l);
            fill_cnt_next = best_reg - s_l;
            fill_val_next = -(VW'(best_reg - s_l));
        end
        if (cmd.respond)
        begin
            result_next = '0;
            if (op_reg == cfa_pkg::OP_ALLOC)
            begin
                if (found_reg && (size_reg != '0))
                begin
                    occ_next                = occ_reg + s_l;
                    result_next.status      = cfa_pkg::RS_OK;
                    result_next.start_index = 7'(at_reg);
                    result_next.run_size    = size_reg;
                end
                else
                begin
                    result_next.status = cfa_pkg::RS_NO_FIT;
                end
            end
            else
            begin
                if (found_reg)
                begin
                    occ_next                = (occ_reg >= bsize_reg) ? (occ_reg - bsize_reg) : '0;
                    result_next.status      = cfa_pkg::RS_OK;
                    result_next.start_index = 7'(at_reg);
                    result_next.run_size    = 8'(best_reg);
                end
                else
                begin
                    result_next.status = cfa_pkg::RS_NO_SUCH;
                end
            end
            result_next.occupied_cells = 8'(occ_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= cfa_pkg::FIT_FIRST;
            fill_ptr_reg <= '0;
            occ_reg      <= '0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            fill_ptr_reg <= fill_ptr_next;
            occ_reg      <= occ_next;
            done_reg     <= cmd.respond;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= request.op;
            size_reg <= request.request_size;
            ord_reg  <= request.release_ordinal;
        end
        pos_reg        <= pos_next;
        at_reg         <= at_next;
        best_reg       <= best_next;
        count_reg      <= count_next;
        prev_neg_reg   <= prev_neg_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        b_reg          <= b_next;
        bsize_reg      <= bsize_next;
        fill_cnt_reg   <= fill_cnt_next;
        fill_val_reg   <= fill_val_next;
        result_reg     <= result_next;
    end

    assign stat.clr_last  = (fill_ptr_reg == AW'(CELLS - 1));
    assign stat.zero_req  = (op_reg == cfa_pkg::OP_ALLOC) && (size_reg == '0);
    assign stat.is_rel    = (op_reg == cfa_pkg::OP_RELEASE);
    assign stat.scan_stop = stop;
    assign stat.found     = found_reg;
    assign stat.has_nb    = nb_pos < (AW + 1)'(CELLS);
    assign stat.has_rem   = CW'(best_reg) > CW'(size_reg);
    assign stat.fill_last = (fill_cnt_reg == LW'(1));

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/contiguous_fit_allocator.sv @@
// Top level of the contiguous fit allocator: controller plus datapath.
// Depends on cfa_pkg, cfa_ctrl and cfa_datapath.
`timescale 1ns / 1ps

// The block keeps a row of CELLS cells as runs: allocated blocks and holes.
// A transaction is taken when start is high and busy is low; one result
// follows on result, marked by a single-cycle done pulse, and the receiver
// cannot hold it off, so it must be captured in that cycle. After reset the
// block clears its cell memory with busy high. An operation walks the runs
// from cell 0, each with one registered memory read and one evaluation, then
// rewrites the chosen run one cell per cycle. A release also reads the run
// that follows the freed block, when there is one, to merge it. fit_mode may be
// written only while the block is idle.
module contiguous_fit_allocator #(
    parameter int CELLS = cfa_pkg::CELLS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_wdata,
    input  logic          start,
    input  cfa_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output cfa_pkg::rsp_t result
);

    cfa_pkg::ctl_cmd_t cmd;
    cfa_pkg::dp_stat_t stat;

    // The controller sequences the walk, the rewrite and the response.
    cfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the cells, the fit register and the occupancy count.
    cfa_datapath #(
        .CELLS (CELLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

@@ src/cfa_checker.sv @@
// Port-level checker for the contiguous fit allocator, bound to the top level.
// Depends on cfa_pkg and contiguous_fit_allocator_assert.svh.
`timescale 1ns / 1ps
`include "contiguous_fit_allocator_assert.svh"

module cfa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input cfa_pkg::rsp_t result
);

    logic fail_done;
    logic empty_fields;
    logic occ_in_range;

    assign fail_done    = done && (result.status != cfa_pkg::RS_OK);
    assign empty_fields = (result.start_index == 7'd0) && (result.run_size == 8'd0);
    assign occ_in_range = (result.occupied_cells <= 8'd128);

    `CFA_ASSERT_NXT(a_done_single, done, !done)
    `CFA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `CFA_ASSERT_IMP(a_done_idle, done, !busy)
    `CFA_ASSERT_IMP(a_fail_empty, fail_done, empty_fields)
    `CFA_ASSERT_IMP(a_occ_range, done, occ_in_range)

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ bench/tb_contiguous_fit_allocator.sv @@
// Self-checking testbench for the contiguous fit allocator.
// Depends on cfa_pkg and the contiguous_fit_allocator top level.
`timescale 1ns / 1ps

module tb_contiguous_fit_allocator;

    localparam int NCELLS = 128;
    localparam int CYCLE_LIMIT = 2000000;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_wdata;
    logic          start;
    cfa_pkg::req_t request;
    logic          busy;
    logic          done;
    cfa_pkg::rsp_t result;

    contiguous_fit_allocator #(.CELLS(NCELLS)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .request(request), .busy(busy), .done(done),
        .result(result)
    );

    // Shadow copy of the cell row: each cell holds its run's signed size.
    int            shadow_runs [NCELLS];
    int            shadow_occupied;
    logic [1:0]    shadow_mode;
    cfa_pkg::rsp_t expected_results [$];
    int            error_count;
    int            cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Length of the run starting at cell i, clamped to the row.
    function automatic int run_length(int i);
        int n;
        n = shadow_runs[i] < 0 ? -shadow_runs[i] : shadow_runs[i];
        if (n == 0) n = 1;
        if (n > NCELLS - i) n = NCELLS - i;
        return n;
    endfunction

    function automatic void fill_run(int first, int len, int v);
        for (int i = first; i < first + len && i < NCELLS; i++) shadow_runs[i] = v;
    endfunction

    function automatic int allocated_blocks();
        int n;
        n = 0;
        for (int i = 0; i < NCELLS; i += run_length(i))
            if (shadow_runs[i] > 0) n++;
        return n;
    endfunction

    // Applies one request to the shadow row and returns the result it implies.
    function automatic cfa_pkg::rsp_t predict_allocation(cfa_pkg::req_t rq);
        cfa_pkg::rsp_t r;
        int len, at, best, sz, k, cnt, b, bsz, first, total, h;
        bit found;
        r = '0;
        found = 1'b0;
        at = 0;
        best = 0;
        if (rq.op == cfa_pkg::OP_ALLOC)
        begin
            sz = rq.request_size;
            if (sz == 0)
            begin
                r.status = cfa_pkg::RS_NO_FIT;
            end
            else
            begin
                for (int i = 0; i < NCELLS; i += len)
                begin
                    len = run_length(i);
                    if (shadow_runs[i] >= 0 || len < sz) continue;
                    if (shadow_mode == cfa_pkg::FIT_BEST)
                    begin
                        if (!found || len < best)
                        begin
                            found = 1'b1; at = i; best = len;
                        end
                        if (len == sz) break;
                    end
                    else if (shadow_mode == cfa_pkg::FIT_WORST)
                    begin
                        if (!found || len > best)
                        begin
                            found = 1'b1; at = i; best = len;
                        end
                    end
                    else
                    begin
                        found = 1'b1; at = i; best = len;
                        break;
                    end
                end
                if (!found)
                begin
                    r.status = cfa_pkg::RS_NO_FIT;
                end
                else
                begin
                    fill_run(at, sz, sz);
                    if (best > sz) fill_run(at + sz, best - sz, -(best - sz));
                    shadow_occupied += sz;
                    r.status = cfa_pkg::RS_OK;
                    r.start_index = at[6:0];
                    r.run_size = sz[7:0];
                end
            end
        end
        else
        begin
            k = rq.release_ordinal;
            cnt = 0;
            b = 0;
            bsz = 0;
            for (int i = 0; i < NCELLS; i += len)
            begin
                len = run_length(i);
                if (shadow_runs[i] > 0)
                begin
                    if (cnt == k)
                    begin
                        found = 1'b1; b = i; bsz = len;
                        break;
                    end
                    cnt++;
                end
            end
            if (!found)
            begin
                r.status = cfa_pkg::RS_NO_SUCH;
            end
            else
            begin
                first = b;
                total = bsz;
                // Merge with a hole on the low side and then on the high side.
                if (b > 0 && shadow_runs[b-1] < 0)
                begin
                    h = -shadow_runs[b-1];
                    if (h > b) h = b;
                    first = b - h;
                    total += h;
                end
                if (b + bsz < NCELLS && shadow_runs[b+bsz] < 0)
                    total += run_length(b + bsz);
                fill_run(first, total, -total);
                shadow_occupied = shadow_occupied >= bsz ? shadow_occupied - bsz : 0;
                r.status = cfa_pkg::RS_OK;
                r.start_index = first[6:0];
                r.run_size = total[7:0];
            end
        end
        r.occupied_cells = shadow_occupied[7:0];
        return r;
    endfunction

    // Short random pause: mostly none or short, now and then a long one.
    task automatic random_pause();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
            ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
        repeat (n) @(posedge clk);
    endtask

    // Presents one request and waits for the block to take it.
    task automatic send_request(cfa_pkg::op_t op, int sz, int ord);
        cfa_pkg::req_t rq;
        rq.op = op;
        rq.request_size = sz[7:0];
        rq.release_ordinal = ord[6:0];
        start <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        expected_results.push_back(predict_allocation(rq));
        start <= 1'b0;
        request <= '{op: cfa_pkg::op_t'($urandom_range(0, 1)), request_size: 8'($urandom),
                     release_ordinal: 7'($urandom)};
        // The block stays busy after it takes a transaction.
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge clk);
        // A result has no gap behind it, but let the block settle back to idle.
        repeat (8) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_fit_mode(logic [1:0] m);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 2'($urandom);
        shadow_mode = m;
    endtask

    // Directed corner cases: zero size, oversize, whole row, missing block
    // and merges on both sides.
    task automatic test_directed();
        send_request(cfa_pkg::OP_ALLOC, 0, 0);
        send_request(cfa_pkg::OP_ALLOC, 129, 0);
        send_request(cfa_pkg::OP_ALLOC, 255, 127);
        send_request(cfa_pkg::OP_RELEASE, 0, 0);
        send_request(cfa_pkg::OP_ALLOC, 128, 0);
        send_request(cfa_pkg::OP_ALLOC, 1, 0);
        send_request(cfa_pkg::OP_RELEASE, 127, 127);
        send_request(cfa_pkg::OP_RELEASE, 0, 0);
        send_request(cfa_pkg::OP_ALLOC, 10, 0);
        send_request(cfa_pkg::OP_ALLOC, 20, 0);
        send_request(cfa_pkg::OP_ALLOC, 5, 0);
        send_request(cfa_pkg::OP_RELEASE, 0, 0);
        send_request(cfa_pkg::OP_RELEASE, 1, 0);
        send_request(cfa_pkg::OP_RELEASE, 0, 0);
        send_request(cfa_pkg::OP_ALLOC, 1, 0);
        send_request(cfa_pkg::OP_ALLOC, 127, 0);
        send_request(cfa_pkg::OP_RELEASE, 1, 0);
        send_request(cfa_pkg::OP_RELEASE, 0, 0);
    endtask

    task automatic test_fit_modes();
        set_fit_mode(cfa_pkg::FIT_BEST);
        send_request(cfa_pkg::OP_ALLOC, 8, 0);
        send_request(cfa_pkg::OP_ALLOC, 30, 0);
        send_request(cfa_pkg::OP_ALLOC, 4, 0);
        send_request(cfa_pkg::OP_ALLOC, 40, 0);
        send_request(cfa_pkg::OP_RELEASE, 0, 0);
        send_request(cfa_pkg::OP_RELEASE, 1, 0);
        send_request(cfa_pkg::OP_ALLOC, 3, 0);
        set_fit_mode(cfa_pkg::FIT_WORST);
        send_request(cfa_pkg::OP_ALLOC, 3, 0);
        set_fit_mode(2'd3);
        send_request(cfa_pkg::OP_ALLOC, 2, 0);
    endtask

    // Random mix per fit mode, leaning on small sizes so the row fragments.
    task automatic test_random(int count);
        int sz, nb;
        for (int n = 0; n < count; n++)
        begin
            if (n % 140 == 0) set_fit_mode(2'($urandom_range(0, 3)));
            nb = allocated_blocks();
            if ($urandom_range(0, 99) < 55)
            begin
                case ($urandom_range(0, 9))
                    0:       sz = $urandom_range(0, 255);
                    1:       sz = $urandom_range(33, 128);
                    default: sz = $urandom_range(1, 16);
                endcase
                send_request(cfa_pkg::OP_ALLOC, sz, $urandom_range(0, 127));
            end
            else
            begin
                send_request(cfa_pkg::OP_RELEASE, $urandom_range(0, 255),
                             ($urandom_range(0, 9) == 0 || nb == 0) ?
                             $urandom_range(0, 127) : $urandom_range(0, nb - 1));
            end
            random_pause();
        end
    endtask

    // Each done pulse is one transaction, checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                cfa_pkg::rsp_t e;
                e = expected_results.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, result.status);
                    error_count++;
                end
                if (result.start_index !== e.start_index)
                begin
                    $error("start_index: expected %0d, got %0d",
                           e.start_index, result.start_index);
                    error_count++;
                end
                if (result.run_size !== e.run_size)
                begin
                    $error("run_size: expected %0d, got %0d", e.run_size, result.run_size);
                    error_count++;
                end
                if (result.occupied_cells !== e.occupied_cells)
                begin
                    $error("occupied_cells: expected %0d, got %0d",
                           e.occupied_cells, result.occupied_cells);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd0;
        start = 1'b0;
        request = '0;
        fill_run(0, NCELLS, -NCELLS);
        shadow_occupied = 0;
        shadow_mode = cfa_pkg::FIT_FIRST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fit_modes();
        test_random(700);
        drain();
        if (expected_results.size() != 0) error_count++;
        if (error_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
